// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the checker file
// no dependencies; clock and, for ASSERT_CLK, active-low reset are passed in by the user
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("clocked assertion failed");

// clocked property, also checked during reset
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) \
		else $error("unconditional assertion failed");

`endif

// ===== hw/rtl/lpcf_pkg.sv =====
// shared types and constants of the length-prefixed chunk framer
// no dependencies
`timescale 1ns / 1ps

package lpcf_pkg;

	typedef enum logic [1:0] {
		ST_FILL,
		ST_HDR,
		ST_DATA
	} state_t;

	localparam logic [7:0] SYNC_CHAR  = 8'h32;
	localparam logic [7:0] DIGIT_BASE = 8'h30;

	// header byte positions
	localparam logic [2:0] HDR_LAST_SYNC = 3'd3;
	localparam logic [2:0] HDR_DIGIT0    = 3'd4;
	localparam logic [2:0] HDR_DIGIT1    = 3'd5;

	localparam logic [6:0] TWO_DIGIT_MIN = 7'd10;

	typedef struct packed {
		logic [3:0] tens;
		logic [3:0] ones;
	} dec_t;

	// decimal split for 0..99 via reciprocal multiply (205 / 2048)
	function automatic dec_t dec_split(input logic [6:0] n);
		logic [14:0] p;
		logic [6:0]  t10;
		dec_t        r;
		p      = 15'(n) * 15'd205;
		r.tens = p[14:11];
		t10    = 7'(r.tens) * 7'd10;
		r.ones = 4'(n - t10);
		return r;
	endfunction

	function automatic logic [7:0] digit_char(input logic [3:0] d);
		return DIGIT_BASE | {4'b0000, d};
	endfunction

endpackage

// ===== hw/rtl/length_prefixed_chunk_framer_top.sv =====
// Length-prefixed chunk framer, top level.
// Input channel: in_valid / in_stall carrying in_char and is_final; one
// character per transaction, is_final on the last character of a message.
// Output channel: out_valid / out_stall carrying out_char and run_end.
// Characters collect in a row of CHUNK_CHARS cells that shift toward cell 0.
// A chunk closes when CHUNK_CHARS characters are held or is_final arrives;
// it then goes out as four '2' sync bytes, the length in decimal ASCII
// (one or two digits) and the characters in arrival order, run_end on the
// last byte. Characters are taken one per cycle while in_stall is low;
// nothing comes out for a character unless it closes a chunk. The header
// of a chunk is 5 or 6 bytes, and its alignment shifts start alongside it:
// the row shifts once per cycle to bring the oldest character to cell 0,
// and the output register moves one byte per cycle. in_stall stays high
// while a chunk is being emitted. When out_stall is high the output
// register holds its byte and emission pauses (alignment shifts continue).
// Reset clears the fill count, the sequencer and out_valid; cells need none.
// Depends on lpcf_pkg, lpcf_cell and lpcf_ctrl.
`timescale 1ns / 1ps

module length_prefixed_chunk_framer_top #(
	parameter int CHUNK_CHARS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_char,
	input  logic       is_final,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       run_end
);

	logic [7:0] chain_w [CHUNK_CHARS];
	logic       shift;

	genvar gi;
	generate
		for (gi = 0; gi < CHUNK_CHARS; gi++) begin : g_cell
			if (gi == CHUNK_CHARS - 1) begin : g_tail
				lpcf_cell u_cell (
					.clk  (clk),
					.shift(shift),
					.din  (in_char),
					.dout (chain_w[gi])
				);
			end else begin : g_body
				lpcf_cell u_cell (
					.clk  (clk),
					.shift(shift),
					.din  (chain_w[gi+1]),
					.dout (chain_w[gi])
				);
			end
		end
	endgenerate

	lpcf_ctrl #(
		.CHUNK_CHARS(CHUNK_CHARS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_final (is_final),
		.in_stall (in_stall),
		.head_char(chain_w[0]),
		.shift    (shift),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_char (out_char),
		.out_end  (run_end)
	);

endmodule

// ===== hw/rtl/lpcf_cell.sv =====
// one storage cell of the character shift chain
// depends on nothing; instantiated in a row by the top level
`timescale 1ns / 1ps

module lpcf_cell (
	input  logic       clk,
	input  logic       shift,
	input  logic [7:0] din,
	output logic [7:0] dout
);

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= din;
		end
	end

	assign dout = data_q;

endmodule

// ===== hw/rtl/lpcf_ctrl.sv =====
// framing sequencer: fill count, header generation, chain alignment, output register
// depends on lpcf_pkg
`timescale 1ns / 1ps

module lpcf_ctrl #(
	parameter int CHUNK_CHARS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_final,
	output logic       in_stall,
	input  logic [7:0] head_char,
	output logic       shift,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic       out_end
);

	localparam int FW = $clog2(CHUNK_CHARS + 1);
	localparam logic [FW-1:0] FULL = FW'(CHUNK_CHARS);

	lpcf_pkg::state_t state_q, state_d;
	logic [FW-1:0] fill_q, fill_d;
	logic [FW-1:0] len_q, len_d;
	logic [FW-1:0] align_q, align_d;
	logic [FW-1:0] left_q, left_d;
	logic [2:0]    idx_q, idx_d;
	logic          two_q, two_d;
	logic [3:0]    tens_q, tens_d;
	logic [3:0]    ones_q, ones_d;

	logic          ov_q;
	logic [7:0]    oc_q;
	logic          oe_q;

	logic          load;
	logic          emit;
	logic [7:0]    emit_char;
	logic          emit_end;
	logic [FW-1:0] n_w;
	lpcf_pkg::dec_t dec_w;

	assign load  = !ov_q || !out_stall;
	assign n_w   = fill_q + FW'(1);
	assign dec_w = lpcf_pkg::dec_split(7'(n_w));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lpcf_pkg::ST_FILL;
			fill_q  <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
			if (load) begin
				ov_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		len_q   <= len_d;
		align_q <= align_d;
		left_q  <= left_d;
		idx_q   <= idx_d;
		two_q   <= two_d;
		tens_q  <= tens_d;
		ones_q  <= ones_d;
		if (load) begin
			oc_q <= emit_char;
			oe_q <= emit_end;
		end
	end

	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		len_d     = len_q;
		align_d   = align_q;
		left_d    = left_q;
		idx_d     = idx_q;
		two_d     = two_q;
		tens_d    = tens_q;
		ones_d    = ones_q;
		in_stall  = 1'b1;
		shift     = 1'b0;
		emit      = 1'b0;
		emit_char = lpcf_pkg::SYNC_CHAR;
		emit_end  = 1'b0;
		case (state_q)
			lpcf_pkg::ST_FILL: begin
				in_stall = 1'b0;
				if (in_valid) begin
					shift = 1'b1;
					if (in_final || n_w == FULL) begin
						state_d = lpcf_pkg::ST_HDR;
						fill_d  = '0;
						len_d   = n_w;
						align_d = FULL - n_w;
						idx_d   = '0;
						two_d   = 7'(n_w) >= lpcf_pkg::TWO_DIGIT_MIN;
						tens_d  = dec_w.tens;
						ones_d  = dec_w.ones;
					end else begin
						fill_d = n_w;
					end
				end
			end
			lpcf_pkg::ST_HDR: begin
				// alignment shifts run alongside the header bytes
				if (align_q != '0) begin
					shift   = 1'b1;
					align_d = align_q - FW'(1);
				end
				if (load) begin
					emit = 1'b1;
					if (idx_q == lpcf_pkg::HDR_DIGIT0) begin
						emit_char = lpcf_pkg::digit_char(two_q ? tens_q : ones_q);
					end else if (idx_q == lpcf_pkg::HDR_DIGIT1) begin
						emit_char = lpcf_pkg::digit_char(ones_q);
					end
					if ((idx_q == lpcf_pkg::HDR_DIGIT0 && !two_q) ||
						idx_q == lpcf_pkg::HDR_DIGIT1) begin
						state_d = lpcf_pkg::ST_DATA;
						left_d  = len_q;
					end else begin
						idx_d = idx_q + 3'd1;
					end
				end
			end
			lpcf_pkg::ST_DATA: begin
				if (align_q != '0) begin
					shift   = 1'b1;
					align_d = align_q - FW'(1);
				end else if (load) begin
					emit      = 1'b1;
					emit_char = head_char;
					emit_end  = left_q == FW'(1);
					shift     = 1'b1;
					left_d    = left_q - FW'(1);
					if (left_q == FW'(1)) begin
						state_d = lpcf_pkg::ST_FILL;
					end
				end
			end
			default: begin
				state_d = lpcf_pkg::ST_FILL;
			end
		endcase
	end

	assign out_valid = ov_q;
	assign out_char  = oc_q;
	assign out_end   = oe_q;

endmodule

// ===== hw/rtl/lpcf_checker.sv =====
// port-level checks for the chunk framer, bound to the top level
// depends on assert_macros.svh, lpcf_pkg and length_prefixed_chunk_framer_top
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpcf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] in_char,
	input logic       is_final,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_char,
	input logic       run_end
);

	// a stalled output byte holds
	`ASSERT_CLK(a_out_hold, clk, arst_n, (out_valid && out_stall) |=> (out_valid && $stable(out_char) && $stable(run_end)))

	// no new character is taken while a frame is still coming out
	`ASSERT_CLK(a_no_input_mid_frame, clk, arst_n, (out_valid && !run_end) |-> in_stall)

	// a final character always closes a chunk, so input stops right after it
	`ASSERT_CLK(a_final_stalls, clk, arst_n, (in_valid && !in_stall && is_final) |=> in_stall)

	// right after a frame's last byte leaves, the output is empty or starts a new frame
	`ASSERT_CLK(a_end_then_sync, clk, arst_n, (out_valid && !out_stall && run_end) |=> (!out_valid || (out_char == lpcf_pkg::SYNC_CHAR && !run_end)))

endmodule

bind length_prefixed_chunk_framer_top lpcf_checker u_lpcf_checker (.*);
